// ===== rtl/gpe_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO port package
// Shared types, register indexes, pin state codes and alternate-function map.
// ----------------------------------------------------------------------------
package gpe_pkg;

	localparam int PIN_COUNT = 32;
	localparam int PIN_SLOTS = 32;
	localparam int NUM_REGS  = 17;

	localparam logic [PIN_SLOTS-1:0] PIN_MASK =
		PIN_SLOTS'((65'd1 << PIN_COUNT) - 65'd1);

	localparam logic [4:0] REG_VALUE     = 5'd0;
	localparam logic [4:0] REG_IN_EN     = 5'd1;
	localparam logic [4:0] REG_OUT_EN    = 5'd2;
	localparam logic [4:0] REG_PORT      = 5'd3;
	localparam logic [4:0] REG_PULLUP    = 5'd4;
	localparam logic [4:0] REG_RISE_EN   = 5'd6;
	localparam logic [4:0] REG_RISE_PEND = 5'd7;
	localparam logic [4:0] REG_FALL_EN   = 5'd8;
	localparam logic [4:0] REG_FALL_PEND = 5'd9;
	localparam logic [4:0] REG_IOF_EN    = 5'd14;
	localparam logic [4:0] REG_IOF_SEL   = 5'd15;
	localparam logic [4:0] REG_LAST      = 5'd16;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_PIN   = 2'd2;

	localparam logic [1:0] LVL_LOW      = 2'd0;
	localparam logic [1:0] LVL_HIGH     = 2'd1;
	localparam logic [1:0] LVL_RELEASED = 2'd2;

	typedef enum logic [2:0] {
		PC_REL  = 3'd0,
		PC_LOW  = 3'd1,
		PC_HIGH = 3'd2,
		PC_URX  = 3'd3,
		PC_UTX  = 3'd4,
		PC_SPI  = 3'd5,
		PC_PWM  = 3'd6
	} pin_code_t;

	typedef enum logic [1:0] {
		CMD_NOP   = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_PIN   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [4:0]  reg_index;
		logic [31:0] write_data;
		logic [4:0]  pin_index;
		pin_code_t   pin_code;
	} cmd_t;

	localparam pin_code_t FN_SEL0 [0:31] = '{
		PC_REL, PC_REL, PC_SPI, PC_SPI, PC_SPI, PC_SPI, PC_REL, PC_REL,
		PC_REL, PC_SPI, PC_SPI, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL,
		PC_URX, PC_UTX, PC_URX, PC_REL, PC_REL, PC_REL, PC_REL, PC_UTX,
		PC_REL, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL
	};

	localparam pin_code_t FN_SEL1 [0:31] = '{
		PC_PWM, PC_PWM, PC_PWM, PC_PWM, PC_REL, PC_REL, PC_REL, PC_REL,
		PC_REL, PC_REL, PC_PWM, PC_PWM, PC_PWM, PC_PWM, PC_REL, PC_REL,
		PC_REL, PC_REL, PC_REL, PC_PWM, PC_PWM, PC_PWM, PC_PWM, PC_REL,
		PC_REL, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL, PC_REL
	};

	function automatic pin_code_t iof_func(input logic [4:0] pin, input logic sel);
		pin_code_t f;
		if (sel) begin
			f = FN_SEL1[pin];
		end else begin
			f = FN_SEL0[pin];
		end
		return f;
	endfunction

endpackage

// ===== rtl/gpe_front.sv =====
// ----------------------------------------------------------------------------
// GPIO front end
// Classifies an incoming beat into a decoded command for the queue.
// ----------------------------------------------------------------------------
module gpe_front (
	input  logic [1:0]    op,
	input  logic [4:0]    reg_index,
	input  logic [31:0]   write_data,
	input  logic [4:0]    pin_index,
	input  logic [1:0]    pin_level,
	output gpe_pkg::cmd_t cmd
);
	import gpe_pkg::*;

	always_comb begin
		cmd.reg_index  = reg_index;
		cmd.write_data = write_data;
		cmd.pin_index  = pin_index;
		cmd.kind       = CMD_NOP;
		cmd.pin_code   = PC_REL;
		case (pin_level)
			LVL_LOW:  cmd.pin_code = PC_LOW;
			LVL_HIGH: cmd.pin_code = PC_HIGH;
			default:  cmd.pin_code = PC_REL;
		endcase
		case (op)
			OP_WRITE: begin
				if (reg_index <= REG_LAST && reg_index != REG_VALUE) begin
					cmd.kind = CMD_WRITE;
				end
			end
			OP_READ: cmd.kind = CMD_READ;
			OP_PIN: begin
				if (pin_level == LVL_LOW || pin_level == LVL_HIGH ||
						pin_level == LVL_RELEASED) begin
					cmd.kind = CMD_PIN;
				end
			end
			default: cmd.kind = CMD_NOP;
		endcase
	end

endmodule

// ===== rtl/gpe_queue.sv =====
// ----------------------------------------------------------------------------
// GPIO command queue
// Two-entry queue that decouples the front end from the execution stage.
// ----------------------------------------------------------------------------
module gpe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gpe_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output gpe_pkg::cmd_t head_cmd
);
	import gpe_pkg::*;

	cmd_t       entry_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/gpe_back.sv =====
// ----------------------------------------------------------------------------
// GPIO execution stage
// Holds the port registers and pin state codes, executes one command per beat
// and keeps the result in an output register.
// ----------------------------------------------------------------------------
module gpe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  gpe_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   read_data,
	output logic [31:0]   irq_mask,
	output logic [31:0]   drive_mask,
	output logic [31:0]   drive_level,
	output logic [31:0]   release_mask,
	output logic [31:0]   iof_error_mask
);
	import gpe_pkg::*;

	logic [31:0] regs_q  [0:NUM_REGS-1];
	pin_code_t   codes_q [0:PIN_SLOTS-1];
	logic [31:0] regs_n  [0:NUM_REGS-1];
	pin_code_t   codes_n [0:PIN_SLOTS-1];

	logic        out_valid_q;
	logic [31:0] read_data_q, irq_mask_q, drive_mask_q;
	logic [31:0] drive_level_q, release_mask_q, iof_error_mask_q;
	logic [31:0] rd, irq, dmask, dlev, rel, ierr;

	logic [31:0] prv, nw, ch, up, dis, en, val_oe;
	pin_code_t   prev_code, c, f;

	assign cmd_take = cmd_valid && (!out_valid_q || !out_stall);

	always_comb begin
		regs_n  = regs_q;
		codes_n = codes_q;
		rd      = '0;
		irq     = '0;
		dmask   = '0;
		dlev    = '0;
		rel     = '0;
		ierr    = '0;
		prv     = regs_q[REG_PORT] & regs_q[REG_OUT_EN] & ~regs_q[REG_IOF_EN];
		nw      = cmd.write_data & regs_q[REG_OUT_EN] & ~regs_q[REG_IOF_EN];
		ch      = prv ^ nw;
		up      = cmd.write_data & ~regs_q[REG_PULLUP];
		dis     = regs_q[REG_OUT_EN] & ~cmd.write_data & PIN_MASK;
		en      = ~regs_q[REG_OUT_EN] & cmd.write_data & PIN_MASK;
		val_oe  = (regs_q[REG_VALUE] & ~regs_q[REG_OUT_EN]) |
			(regs_q[REG_PORT] & cmd.write_data);
		prev_code = codes_q[cmd.pin_index];
		c = PC_REL;
		f = PC_REL;
		case (cmd.kind)
			CMD_WRITE: begin
				case (cmd.reg_index)
					REG_PORT: begin
						if (ch != '0) begin
							regs_n[REG_VALUE] = (regs_q[REG_VALUE] & ~regs_q[REG_OUT_EN]) | nw;
							for (int i = 0; i < PIN_SLOTS; i++) begin
								if (ch[i] && PIN_MASK[i]) begin
									codes_n[i] = nw[i] ? PC_HIGH : PC_LOW;
								end
							end
							dmask = ch & PIN_MASK;
							dlev  = nw & ch & PIN_MASK;
						end
					end
					REG_PULLUP: begin
						regs_n[REG_VALUE] = regs_q[REG_VALUE] | up;
						for (int i = 0; i < PIN_SLOTS; i++) begin
							if (up[i] && PIN_MASK[i]) begin
								codes_n[i] = PC_HIGH;
							end
						end
					end
					REG_OUT_EN: begin
						regs_n[REG_VALUE] = val_oe;
						for (int i = 0; i < PIN_SLOTS; i++) begin
							if (dis[i]) begin
								codes_n[i] = PC_REL;
							end else if (en[i]) begin
								codes_n[i] = val_oe[i] ? PC_HIGH : PC_LOW;
							end
						end
						rel   = dis;
						dmask = en;
						dlev  = val_oe & en;
					end
					default: begin
					end
				endcase
				regs_n[cmd.reg_index] = cmd.write_data;
				if (cmd.reg_index == REG_IOF_EN || cmd.reg_index == REG_IOF_SEL) begin
					for (int i = 0; i < PIN_SLOTS; i++) begin
						if (PIN_MASK[i] && regs_n[REG_IOF_EN][i]) begin
							f = iof_func(5'(i), regs_n[REG_IOF_SEL][i]);
							if (f == PC_REL) begin
								ierr[i] = 1'b1;
							end else begin
								codes_n[i] = f;
							end
						end
					end
				end
			end
			CMD_READ: begin
				if (cmd.reg_index <= REG_LAST) begin
					rd = regs_q[cmd.reg_index];
				end
			end
			CMD_PIN: begin
				codes_n[cmd.pin_index] = cmd.pin_code;
				if (prev_code != cmd.pin_code) begin
					for (int i = 0; i < PIN_SLOTS; i++) begin
						if (PIN_MASK[i] && regs_q[REG_IN_EN][i]) begin
							c = codes_n[i];
							if (c == PC_REL) begin
								c = regs_q[REG_PULLUP][i] ? PC_HIGH : PC_LOW;
							end
							codes_n[i] = c;
							if (!regs_q[REG_VALUE][i] && c == PC_HIGH) begin
								if (regs_q[REG_RISE_EN][i] && regs_q[REG_RISE_PEND][i]) begin
									regs_n[REG_RISE_PEND][i] = 1'b0;
									irq[i] = 1'b1;
								end
								regs_n[REG_VALUE][i] = 1'b1;
							end else if (regs_q[REG_VALUE][i] && c == PC_LOW) begin
								if (regs_q[REG_FALL_EN][i] && regs_q[REG_FALL_PEND][i]) begin
									regs_n[REG_FALL_PEND][i] = 1'b0;
									irq[i] = 1'b1;
								end
								regs_n[REG_VALUE][i] = 1'b0;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				regs_q[r] <= '0;
			end
			for (int p = 0; p < PIN_SLOTS; p++) begin
				codes_q[p] <= PC_REL;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				regs_q      <= regs_n;
				codes_q     <= codes_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			read_data_q      <= rd;
			irq_mask_q       <= irq;
			drive_mask_q     <= dmask;
			drive_level_q    <= dlev;
			release_mask_q   <= rel;
			iof_error_mask_q <= ierr;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign irq_mask       = irq_mask_q;
	assign drive_mask     = drive_mask_q;
	assign drive_level    = drive_level_q;
	assign release_mask   = release_mask_q;
	assign iof_error_mask = iof_error_mask_q;

`ifndef SYNTHESIS
	a_level_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((drive_level_q & ~drive_mask_q) == '0))
		else $error("drive level outside drive mask");
	a_drive_release_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((drive_mask_q & release_mask_q) == '0))
		else $error("pin both driven and released");
	a_fired_pend_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> ((irq_mask_q & regs_q[REG_RISE_PEND] & regs_q[REG_FALL_PEND]
			& regs_q[REG_RISE_EN] & regs_q[REG_FALL_EN]) == '0))
		else $error("fired pin still pending in both directions");
`endif

endmodule

// ===== rtl/gpio_port_with_edge_interrupts.sv =====
// ----------------------------------------------------------------------------
// GPIO port with edge interrupts
// Register access and pin-change events for a 32-pin port; reports drive,
// release, alternate-function errors and fired edge interrupts per beat.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat, in order. The block
// takes one beat per cycle while in_stall is low: a beat is classified and
// queued on the edge that accepts it, the execution stage applies it to the
// port registers and pin state, and the result is offered from an output
// register, so it passes through the queue and that register before it can
// be taken. A two-entry queue sits between the front end and the execution
// stage; in_stall rises while it holds two beats, which only happens when
// out_stall holds results back. irq_base is stored for software; bit i of
// irq_mask stands for interrupt irq_base plus i.
module gpio_port_with_edge_interrupts (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [9:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [4:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic [4:0]  pin_index,
	input  logic [1:0]  pin_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [31:0] irq_mask,
	output logic [31:0] drive_mask,
	output logic [31:0] drive_level,
	output logic [31:0] release_mask,
	output logic [31:0] iof_error_mask
);
	import gpe_pkg::*;

	cmd_t       front_cmd;
	cmd_t       head_cmd;
	logic       q_full;
	logic       q_not_empty;
	logic       q_pop;
	logic       q_push;
	logic [9:0] irq_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_base_q <= '0;
		end else if (cfg_write_en) begin
			irq_base_q <= cfg_write_data;
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	gpe_front u_front (
		.op         (op),
		.reg_index  (reg_index),
		.write_data (write_data),
		.pin_index  (pin_index),
		.pin_level  (pin_level),
		.cmd        (front_cmd)
	);

	gpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (head_cmd)
	);

	gpe_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_not_empty),
		.cmd            (head_cmd),
		.cmd_take       (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.irq_mask       (irq_mask),
		.drive_mask     (drive_mask),
		.drive_level    (drive_level),
		.release_mask   (release_mask),
		.iof_error_mask (iof_error_mask)
	);

`ifndef SYNTHESIS
	a_cfg_stored: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |=> (irq_base_q == $past(cfg_write_data)))
		else $error("irq base not stored");
`endif

endmodule
